/* hw/rtl/graph_cycle_detector_macros.svh */
// assertion macros shared by the cycle detector modules
`ifndef GRAPH_CYCLE_DETECTOR_MACROS_SVH
`define GRAPH_CYCLE_DETECTOR_MACROS_SVH

// condition that holds at every clock edge outside reset
`define GCD_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// condition that, once seen, forces another one in the next cycle
`define GCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/gcd_pkg.sv */
// shared constants, types and a helper function of the cycle detector
package gcd_pkg;

   localparam int NODE_W  = 6;
   localparam int SLOTS   = 2 ** NODE_W;
   localparam int DEPTH_W = NODE_W + 1;
   localparam int FUNC_W  = 2;
   localparam int NODES   = 64;

   localparam logic [SLOTS-1:0] NODE_MASK = {SLOTS{1'b1}} >> (SLOTS - NODES);

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   typedef struct packed {
      logic upd_read;
      logic upd_add;
      logic upd_write;
      logic q_init;
      logic root_skip;
      logic root_push;
      logic cand_push;
      logic pop;
      logic top_load;
      logic finish;
   } gcd_cmd_type;

   typedef struct packed {
      logic req_in_range;
      logic root_done;
      logic root_visited;
      logic hit;
      logic cand_any;
      logic depth_one;
   } gcd_status_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [NODE_W-1:0] lowest_set(input logic [SLOTS-1:0] v);
      logic [NODE_W-1:0] k;
      k = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            k = NODE_W'(i);
         end
      end
      return k;
   endfunction

endpackage

/* hw/rtl/gcd_if.sv */
// request and response channel interfaces of the cycle detector
interface gcd_req_if;
   logic                        valid;
   logic                        ready;
   logic [gcd_pkg::FUNC_W-1:0]  func;
   logic [gcd_pkg::NODE_W-1:0]  from_node;
   logic [gcd_pkg::NODE_W-1:0]  to_node;

   modport source (output valid, func, from_node, to_node, input ready);
   modport sink (input valid, func, from_node, to_node, output ready);
endinterface

interface gcd_rsp_if;
   logic valid;
   logic ready;
   logic cycle_found;

   modport source (output valid, cycle_found, input ready);
   modport sink (input valid, cycle_found, output ready);
endinterface

/* hw/rtl/gcd_ram.sv */
// generic single write port ram with registered read
module gcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/gcd_dp.sv */
// datapath: edge matrix, search marks, search stack and root counter
`include "graph_cycle_detector_macros.svh"

module gcd_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [gcd_pkg::NODE_W-1:0]   req_from_node,
   input  logic [gcd_pkg::NODE_W-1:0]   req_to_node,
   input  gcd_pkg::gcd_cmd_type         cmd,
   output gcd_pkg::gcd_status_type      status
);

   logic [gcd_pkg::SLOTS-1:0]   visited_ff, visited_in;
   logic [gcd_pkg::SLOTS-1:0]   onpath_ff, onpath_in;
   logic [gcd_pkg::SLOTS-1:0]   row_valid_ff, row_valid_in;
   logic [gcd_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic [gcd_pkg::DEPTH_W-1:0] root_ff, root_in;
   logic [gcd_pkg::NODE_W-1:0]  top_ff, top_in;
   logic                        rd_valid_ff;
   logic [gcd_pkg::NODE_W-1:0]  from_ff;
   logic [gcd_pkg::NODE_W-1:0]  to_ff;
   logic                        add_ff;

   logic [gcd_pkg::SLOTS-1:0]   edge_rdata, row, cand, upd_row, to_bit;
   logic [gcd_pkg::NODE_W-1:0]  stack_rdata, cand_node, push_node, edge_rd_addr;
   logic [gcd_pkg::DEPTH_W-1:0] depth_less2;
   logic                        edge_rd_en, push;

   // adjacency rows, a row never written reads as empty
   gcd_ram #(.WIDTH(gcd_pkg::SLOTS), .DEPTH(gcd_pkg::SLOTS)) u_edge_ram (
      .clock   (clock),
      .wr_en   (cmd.upd_write),
      .wr_addr (from_ff),
      .wr_data (upd_row),
      .rd_en   (edge_rd_en),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rdata)
   );

   gcd_ram #(.WIDTH(gcd_pkg::NODE_W), .DEPTH(gcd_pkg::SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (depth_ff[gcd_pkg::NODE_W-1:0]),
      .wr_data (push_node),
      .rd_en   (cmd.pop),
      .rd_addr (depth_less2[gcd_pkg::NODE_W-1:0]),
      .rd_data (stack_rdata)
   );

   assign row         = (rd_valid_ff ? edge_rdata : '0) & gcd_pkg::NODE_MASK;
   assign cand        = row & ~visited_ff;
   assign cand_node   = gcd_pkg::lowest_set(cand);
   assign push        = cmd.root_push | cmd.cand_push;
   assign push_node   = cmd.root_push ? root_ff[gcd_pkg::NODE_W-1:0] : cand_node;
   assign depth_less2 = depth_ff - gcd_pkg::DEPTH_W'(2);
   assign to_bit      = gcd_pkg::SLOTS'(1) << to_ff;
   assign upd_row     = add_ff ? (row | to_bit) : (row & ~to_bit);
   assign edge_rd_en  = cmd.upd_read | push | cmd.top_load;

   always_comb begin
      if (cmd.upd_read) begin
         edge_rd_addr = req_from_node;
      end else if (cmd.top_load) begin
         edge_rd_addr = stack_rdata;
      end else begin
         edge_rd_addr = push_node;
      end
   end

   always_comb begin
      status.req_in_range = ({1'b0, req_from_node} < gcd_pkg::DEPTH_W'(gcd_pkg::NODES)) &&
                            ({1'b0, req_to_node} < gcd_pkg::DEPTH_W'(gcd_pkg::NODES));
      status.root_done    = (root_ff == gcd_pkg::DEPTH_W'(gcd_pkg::NODES));
      status.root_visited = visited_ff[root_ff[gcd_pkg::NODE_W-1:0]];
      status.hit          = |(row & onpath_ff);
      status.cand_any     = |cand;
      status.depth_one    = (depth_ff == gcd_pkg::DEPTH_W'(1));
   end

   always_comb begin
      visited_in   = visited_ff;
      onpath_in    = onpath_ff;
      depth_in     = depth_ff;
      root_in      = root_ff;
      top_in       = top_ff;
      row_valid_in = row_valid_ff;
      if (cmd.q_init) begin
         visited_in = '0;
         onpath_in  = '0;
         depth_in   = '0;
         root_in    = '0;
      end
      if (cmd.root_skip || cmd.root_push) begin
         root_in = root_ff + gcd_pkg::DEPTH_W'(1);
      end
      if (push) begin
         visited_in = visited_ff | (gcd_pkg::SLOTS'(1) << push_node);
         onpath_in  = onpath_ff | (gcd_pkg::SLOTS'(1) << push_node);
         depth_in   = depth_ff + gcd_pkg::DEPTH_W'(1);
         top_in     = push_node;
      end
      if (cmd.pop) begin
         onpath_in = onpath_ff & ~(gcd_pkg::SLOTS'(1) << top_ff);
         depth_in  = depth_ff - gcd_pkg::DEPTH_W'(1);
      end
      if (cmd.top_load) begin
         top_in = stack_rdata;
      end
      if (cmd.finish) begin
         onpath_in = '0;
         depth_in  = '0;
      end
      if (cmd.upd_write) begin
         row_valid_in[from_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff   <= '0;
         onpath_ff    <= '0;
         row_valid_ff <= '0;
         depth_ff     <= '0;
         root_ff      <= '0;
         top_ff       <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         visited_ff   <= visited_in;
         onpath_ff    <= onpath_in;
         row_valid_ff <= row_valid_in;
         depth_ff     <= depth_in;
         root_ff      <= root_in;
         top_ff       <= top_in;
         if (edge_rd_en) begin
            rd_valid_ff <= row_valid_ff[edge_rd_addr];
         end
      end
   end

   // edge update operands
   always_ff @(posedge clock) begin
      if (cmd.upd_read) begin
         from_ff <= req_from_node;
         to_ff   <= req_to_node;
         add_ff  <= cmd.upd_add;
      end
   end

   `GCD_ASSERT(a_path_matches_depth, $countones(onpath_ff) == int'(depth_ff), "path marks disagree with stack depth")
   `GCD_ASSERT(a_path_within_visited, (onpath_ff & ~visited_ff) == '0, "node on path but not visited")
   `GCD_ASSERT(a_depth_bounded, depth_ff <= gcd_pkg::DEPTH_W'(gcd_pkg::NODES), "stack depth above node count")

endmodule

/* hw/rtl/gcd_ctrl.sv */
// controller: sequences edge updates and the depth-first search, holds the response
`include "graph_cycle_detector_macros.svh"

module gcd_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [gcd_pkg::FUNC_W-1:0]   req_func,
   output logic                         req_ready,
   output logic                         rsp_valid,
   output logic                         rsp_cycle_found,
   input  logic                         rsp_ready,
   input  gcd_pkg::gcd_status_type      status,
   output gcd_pkg::gcd_cmd_type         cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UPD    = 3'd1;
   localparam logic [2:0] S_QINIT  = 3'd2;
   localparam logic [2:0] S_ROOT   = 3'd3;
   localparam logic [2:0] S_EXPAND = 3'd4;
   localparam logic [2:0] S_POPTOP = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       found_ff, found_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_data_ff, rsp_data_in;

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cycle_found = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_func) inside
                  gcd_pkg::FUNC_ADD, gcd_pkg::FUNC_REMOVE: begin
                     if (status.req_in_range) begin
                        cmd.upd_read = 1'b1;
                        cmd.upd_add  = (req_func == gcd_pkg::FUNC_ADD);
                        state_in     = S_UPD;
                     end
                  end
                  gcd_pkg::FUNC_QUERY: state_in = S_QINIT;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_UPD: begin
            cmd.upd_write = 1'b1;
            state_in      = S_IDLE;
         end
         S_QINIT: begin
            cmd.q_init = 1'b1;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            if (status.root_done) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else if (status.root_visited) begin
               cmd.root_skip = 1'b1;
            end else begin
               cmd.root_push = 1'b1;
               state_in      = S_EXPAND;
            end
         end
         S_EXPAND: begin
            if (status.hit) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else if (status.cand_any) begin
               cmd.cand_push = 1'b1;
            end else begin
               cmd.pop  = 1'b1;
               state_in = status.depth_one ? S_ROOT : S_POPTOP;
            end
         end
         S_POPTOP: begin
            cmd.top_load = 1'b1;
            state_in     = S_EXPAND;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = found_ff;
               cmd.finish   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   `GCD_ASSERT_NEXT(a_upd_two_steps, state_ff == S_UPD, state_ff == S_IDLE, "edge update did not return to idle")
   `GCD_ASSERT_NEXT(a_rsp_from_done, state_ff != S_DONE && !rsp_valid_ff, !rsp_valid_ff, "response raised outside the done step")

endmodule

/* hw/rtl/graph_cycle_detector.sv */
// top level of the directed graph cycle detector
//
// the request channel carries one transaction per operation: func selects
// add edge, remove edge or cycle query, from_node and to_node name the edge.
// an edge update with a node index at or above the node count, and the
// unused function code, are dropped without a response.
// edge updates are accepted with a row read, then write the row, and give
// no response. a query gives exactly one response transaction with cycle_found.
// a query runs a depth-first search from every root in ascending order; its
// length is set by the single read port of the edge row memory, one row per
// step: a start step clears the marks, the root scan skips or pushes each
// root and then ends, each push beyond a root reads the new top row, each pop
// is followed by a top reload unless it empties the stack, and a finish step
// gives the response, much sooner when a cycle shows up early.
// one operation is handled at a time; a new request is taken in the cycle
// after the previous one finishes, even while a response still waits.
// if the receiver stalls, the response stays in the output register and a
// further query waits in its final step until that response is taken.
// synchronous reset empties the graph (per-row valid flags, no clearing
// pass) and drops any pending response; requests are accepted straight away.

module graph_cycle_detector (
   input  logic       clock,
   input  logic       reset,
   gcd_req_if.sink    req_ch,
   gcd_rsp_if.source  rsp_ch
);

   // command and status bundles between controller and datapath
   gcd_pkg::gcd_cmd_type    cmd;
   gcd_pkg::gcd_status_type status;

   // controller: operation decode, search sequencing, response register
   gcd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_func        (req_ch.func),
      .req_ready       (req_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_cycle_found (rsp_ch.cycle_found),
      .rsp_ready       (rsp_ch.ready),
      .status          (status),
      .cmd             (cmd)
   );

   // datapath: edge rows, visited and on-path marks, explicit search stack
   gcd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_from_node (req_ch.from_node),
      .req_to_node   (req_ch.to_node),
      .cmd           (cmd),
      .status        (status)
   );

endmodule
